[rtl/teb_pkg.sv]
// Shared types, constants and microcode step labels for the text edit buffer.
package teb_pkg;

  localparam int unsigned DEF_STORE_BYTES = 4096;

  localparam int unsigned KIND_W  = 4;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DELTA_W = 14;
  localparam int unsigned RIDX_W  = 12;
  localparam int unsigned POS_W   = 13;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 32;

  localparam logic [CFG_AW-3:0] REG_TYPING = '0;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;

  typedef enum logic [KIND_W-1:0] {
    K_INSERT = 4'd0,
    K_BACKSP = 4'd1,
    K_DELETE = 4'd2,
    K_MOVE   = 4'd3,
    K_UP     = 4'd4,
    K_DOWN   = 4'd5,
    K_HOME   = 4'd6,
    K_END    = 4'd7,
    K_CLEAR  = 4'd8,
    K_APPEND = 4'd9
  } kind_e;

  typedef logic [5:0] step_t;

  localparam step_t S_FIN  = 6'd0;
  localparam step_t S_OUT  = 6'd1;
  localparam step_t S_INS0 = 6'd2;
  localparam step_t S_INS1 = 6'd3;
  localparam step_t S_INS2 = 6'd4;
  localparam step_t S_INS3 = 6'd5;
  localparam step_t S_BSP0 = 6'd6;
  localparam step_t S_DEL0 = 6'd7;
  localparam step_t S_RM1  = 6'd8;
  localparam step_t S_RM2  = 6'd9;
  localparam step_t S_RM3  = 6'd10;
  localparam step_t S_MOV0 = 6'd11;
  localparam step_t S_HOM0 = 6'd12;
  localparam step_t S_HOM1 = 6'd13;
  localparam step_t S_HOM2 = 6'd14;
  localparam step_t S_HOM3 = 6'd15;
  localparam step_t S_END0 = 6'd16;
  localparam step_t S_END1 = 6'd17;
  localparam step_t S_END2 = 6'd18;
  localparam step_t S_END3 = 6'd19;
  localparam step_t S_UP0  = 6'd20;
  localparam step_t S_UP1  = 6'd21;
  localparam step_t S_UP2  = 6'd22;
  localparam step_t S_UP3  = 6'd23;
  localparam step_t S_UP4  = 6'd24;
  localparam step_t S_UP5  = 6'd25;
  localparam step_t S_UP6  = 6'd26;
  localparam step_t S_UP7  = 6'd27;
  localparam step_t S_LE1  = 6'd28;
  localparam step_t S_LE2  = 6'd29;
  localparam step_t S_LE3  = 6'd30;
  localparam step_t S_DN0  = 6'd31;
  localparam step_t S_DN1  = 6'd32;
  localparam step_t S_DN2  = 6'd33;
  localparam step_t S_DN3  = 6'd34;
  localparam step_t S_DN4  = 6'd35;
  localparam step_t S_DN5  = 6'd36;
  localparam step_t S_DN6  = 6'd37;
  localparam step_t S_DN7  = 6'd38;
  localparam step_t S_CLR0 = 6'd39;
  localparam step_t S_APP0 = 6'd40;

  typedef enum logic [1:0] {RS_PTR, RS_PM1, RS_PP1, RS_RIDX} rsel_e;
  typedef enum logic [1:0] {WS_NONE, WS_PTR, WS_CUR, WS_LEN} wsel_e;
  typedef enum logic [2:0] {
    P_HOLD, P_CUR, P_CM1, P_LEN, P_INC, P_DEC, P_INCN, P_DECN
  } pop_e;
  typedef enum logic [2:0] {
    C_HOLD, C_INC, C_DEC, C_MOVE, C_PTR, C_COL, C_ZERO, C_LP1
  } cop_e;
  typedef enum logic [1:0] {L_HOLD, L_INC, L_DEC, L_ZERO} lop_e;
  typedef enum logic [1:0] {A_NONE, A_COL, A_TGT} aux_e;
  typedef enum logic [2:0] {
    J_NEVER, J_ALWAYS, J_PZ, J_PL, J_PC, J_P1GL, J_RDN
  } jc_e;

  typedef struct packed {
    jc_e   jc;
    step_t jt;
    rsel_e rsel;
    wsel_e wsel;
    pop_e  pop;
    cop_e  cop;
    lop_e  lop;
    aux_e  aux;
    logic  done;
  } ucw_t;

  typedef struct packed {
    logic ptr_zero;
    logic ptr_eq_len;
    logic ptr_eq_cur;
    logic ptr1_ge_len;
    logic rd_nnl;
  } flags_t;

endpackage

[rtl/teb_useq.sv]
// Microcode sequencer: step counter, control store and conditional jumps.
module teb_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  teb_pkg::step_t  entry_i,
  input  teb_pkg::flags_t flags_i,
  output teb_pkg::ucw_t   ctrl_o,
  output logic            busy_o
);
  import teb_pkg::*;

  typedef enum logic [1:0] {
    SQ_IDLE = 2'b01,
    SQ_RUN  = 2'b10
  } seq_state_e;

  seq_state_e state_q, state_d;
  step_t      pc_q, pc_d;
  ucw_t       cw;
  logic       take;

  function automatic ucw_t uc(input jc_e jc, input step_t jt, input rsel_e rs,
                              input wsel_e ws, input pop_e po, input cop_e co,
                              input lop_e lo, input aux_e ax);
    ucw_t w;
    w.jc   = jc;
    w.jt   = jt;
    w.rsel = rs;
    w.wsel = ws;
    w.pop  = po;
    w.cop  = co;
    w.lop  = lo;
    w.aux  = ax;
    w.done = 1'b0;
    return w;
  endfunction

  function automatic ucw_t rom(input step_t pc);
    ucw_t w;
    w = uc(J_ALWAYS, S_FIN, RS_PTR, WS_NONE, P_HOLD, C_HOLD, L_HOLD, A_NONE);
    unique case (pc)
      S_FIN:  w = uc(J_NEVER, S_FIN, RS_RIDX, WS_NONE, P_HOLD, C_HOLD, L_HOLD, A_NONE);
      S_OUT:  begin
        w = uc(J_NEVER, S_FIN, RS_PTR, WS_NONE, P_HOLD, C_HOLD, L_HOLD, A_NONE);
        w.done = 1'b1;
      end
      S_INS0: w = uc(J_NEVER, S_FIN, RS_PTR, WS_NONE, P_LEN, C_HOLD, L_HOLD, A_NONE);
      S_INS1: w = uc(J_PC, S_INS3, RS_PM1, WS_NONE, P_HOLD, C_HOLD, L_HOLD, A_NONE);
      S_INS2: w = uc(J_ALWAYS, S_INS1, RS_PTR, WS_PTR, P_DEC, C_HOLD, L_HOLD, A_NONE);
      S_INS3: w = uc(J_ALWAYS, S_FIN, RS_PTR, WS_CUR, P_HOLD, C_INC, L_INC, A_NONE);
      S_BSP0: w = uc(J_ALWAYS, S_RM1, RS_PTR, WS_NONE, P_CM1, C_DEC, L_HOLD, A_NONE);
      S_DEL0: w = uc(J_NEVER, S_FIN, RS_PTR, WS_NONE, P_CUR, C_HOLD, L_HOLD, A_NONE);
      S_RM1:  w = uc(J_P1GL, S_RM3, RS_PP1, WS_NONE, P_HOLD, C_HOLD, L_HOLD, A_NONE);
      S_RM2:  w = uc(J_ALWAYS, S_RM1, RS_PTR, WS_PTR, P_INC, C_HOLD, L_HOLD, A_NONE);
      S_RM3:  w = uc(J_ALWAYS, S_FIN, RS_PTR, WS_NONE, P_HOLD, C_HOLD, L_DEC, A_NONE);
      S_MOV0: w = uc(J_ALWAYS, S_FIN, RS_PTR, WS_NONE, P_HOLD, C_MOVE, L_HOLD, A_NONE);
      S_HOM0: w = uc(J_NEVER, S_FIN, RS_PTR, WS_NONE, P_CUR, C_HOLD, L_HOLD, A_NONE);
      S_HOM1: w = uc(J_PZ, S_HOM3, RS_PM1, WS_NONE, P_HOLD, C_HOLD, L_HOLD, A_NONE);
      S_HOM2: w = uc(J_RDN, S_HOM1, RS_PTR, WS_NONE, P_DECN, C_HOLD, L_HOLD, A_NONE);
      S_HOM3: w = uc(J_ALWAYS, S_FIN, RS_PTR, WS_NONE, P_HOLD, C_PTR, L_HOLD, A_NONE);
      S_END0: w = uc(J_NEVER, S_FIN, RS_PTR, WS_NONE, P_CUR, C_HOLD, L_HOLD, A_NONE);
      S_END1: w = uc(J_PL, S_END3, RS_PTR, WS_NONE, P_HOLD, C_HOLD, L_HOLD, A_NONE);
      S_END2: w = uc(J_RDN, S_END1, RS_PTR, WS_NONE, P_INCN, C_HOLD, L_HOLD, A_NONE);
      S_END3: w = uc(J_ALWAYS, S_FIN, RS_PTR, WS_NONE, P_HOLD, C_PTR, L_HOLD, A_NONE);
      S_UP0:  w = uc(J_NEVER, S_FIN, RS_PTR, WS_NONE, P_CUR, C_HOLD, L_HOLD, A_NONE);
      S_UP1:  w = uc(J_PZ, S_UP3, RS_PM1, WS_NONE, P_HOLD, C_HOLD, L_HOLD, A_NONE);
      S_UP2:  w = uc(J_RDN, S_UP1, RS_PTR, WS_NONE, P_DECN, C_HOLD, L_HOLD, A_NONE);
      S_UP3:  w = uc(J_PZ, S_FIN, RS_PTR, WS_NONE, P_HOLD, C_HOLD, L_HOLD, A_COL);
      S_UP4:  w = uc(J_NEVER, S_FIN, RS_PTR, WS_NONE, P_DEC, C_HOLD, L_HOLD, A_NONE);
      S_UP5:  w = uc(J_PZ, S_UP7, RS_PM1, WS_NONE, P_HOLD, C_HOLD, L_HOLD, A_NONE);
      S_UP6:  w = uc(J_RDN, S_UP5, RS_PTR, WS_NONE, P_DECN, C_HOLD, L_HOLD, A_NONE);
      S_UP7:  w = uc(J_NEVER, S_FIN, RS_PTR, WS_NONE, P_HOLD, C_HOLD, L_HOLD, A_TGT);
      S_LE1:  w = uc(J_PL, S_LE3, RS_PTR, WS_NONE, P_HOLD, C_HOLD, L_HOLD, A_NONE);
      S_LE2:  w = uc(J_RDN, S_LE1, RS_PTR, WS_NONE, P_INCN, C_HOLD, L_HOLD, A_NONE);
      S_LE3:  w = uc(J_ALWAYS, S_FIN, RS_PTR, WS_NONE, P_HOLD, C_COL, L_HOLD, A_NONE);
      S_DN0:  w = uc(J_NEVER, S_FIN, RS_PTR, WS_NONE, P_CUR, C_HOLD, L_HOLD, A_NONE);
      S_DN1:  w = uc(J_PZ, S_DN3, RS_PM1, WS_NONE, P_HOLD, C_HOLD, L_HOLD, A_NONE);
      S_DN2:  w = uc(J_RDN, S_DN1, RS_PTR, WS_NONE, P_DECN, C_HOLD, L_HOLD, A_NONE);
      S_DN3:  w = uc(J_NEVER, S_FIN, RS_PTR, WS_NONE, P_CUR, C_HOLD, L_HOLD, A_COL);
      S_DN4:  w = uc(J_PL, S_FIN, RS_PTR, WS_NONE, P_HOLD, C_HOLD, L_HOLD, A_NONE);
      S_DN5:  w = uc(J_RDN, S_DN4, RS_PTR, WS_NONE, P_INCN, C_HOLD, L_HOLD, A_NONE);
      S_DN6:  w = uc(J_NEVER, S_FIN, RS_PTR, WS_NONE, P_INC, C_HOLD, L_HOLD, A_NONE);
      S_DN7:  w = uc(J_ALWAYS, S_LE1, RS_PTR, WS_NONE, P_HOLD, C_HOLD, L_HOLD, A_TGT);
      S_CLR0: w = uc(J_ALWAYS, S_FIN, RS_PTR, WS_NONE, P_HOLD, C_ZERO, L_ZERO, A_NONE);
      S_APP0: w = uc(J_ALWAYS, S_FIN, RS_PTR, WS_LEN, P_HOLD, C_LP1, L_INC, A_NONE);
      default: w = uc(J_ALWAYS, S_FIN, RS_PTR, WS_NONE, P_HOLD, C_HOLD, L_HOLD, A_NONE);
    endcase
    return w;
  endfunction

  always_comb begin
    cw      = uc(J_NEVER, S_FIN, RS_PTR, WS_NONE, P_HOLD, C_HOLD, L_HOLD, A_NONE);
    take    = 1'b0;
    state_d = state_q;
    pc_d    = pc_q;
    unique case (state_q)
      SQ_IDLE: begin
        if (go_i) begin
          state_d = SQ_RUN;
          pc_d    = entry_i;
        end
      end
      SQ_RUN: begin
        cw = rom(pc_q);
        unique case (cw.jc)
          J_NEVER:  take = 1'b0;
          J_ALWAYS: take = 1'b1;
          J_PZ:     take = flags_i.ptr_zero;
          J_PL:     take = flags_i.ptr_eq_len;
          J_PC:     take = flags_i.ptr_eq_cur;
          J_P1GL:   take = flags_i.ptr1_ge_len;
          J_RDN:    take = flags_i.rd_nnl;
          default:  take = 1'b0;
        endcase
        if (cw.done) begin
          state_d = SQ_IDLE;
        end else begin
          pc_d = take ? cw.jt : pc_q + step_t'(1);
        end
      end
      default: state_d = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      pc_q    <= S_FIN;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  assign ctrl_o = cw;
  assign busy_o = (state_q != SQ_IDLE);

endmodule

[rtl/text_edit_buffer_core.sv]
// Text edit buffer top level: command dispatch, datapath, text RAM and register port.
// Each request is one editing command and yields exactly one result, shown for a single
// cycle with done_o in the same cycle as busy falls; the receiver cannot stall, so it must
// take the result in that cycle, and the next request may be accepted in that same cycle.
// Insert, backspace, delete, home and end shift or scan the text byte by byte, and each byte
// takes a read step and then a step that writes or tests it, since the text RAM has
// registered read data. Line down scans at most the whole text once; line up walks the line
// above twice, back to its start and then forward to its end.
module text_edit_buffer_core #(
  parameter int unsigned STORE_BYTES = teb_pkg::DEF_STORE_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [teb_pkg::KIND_W-1:0]  kind_i,
  input  logic [teb_pkg::CHAR_W-1:0]  char_code_i,
  input  logic signed [teb_pkg::DELTA_W-1:0] move_delta_i,
  input  logic [teb_pkg::RIDX_W-1:0]  read_index_i,
  output logic                        done_o,
  output logic [teb_pkg::POS_W-1:0]   cursor_out_o,
  output logic [teb_pkg::POS_W-1:0]   length_out_o,
  output logic [teb_pkg::CHAR_W-1:0]  byte_out_o,
  output logic                        refused_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [teb_pkg::CFG_AW-1:0]  paddr,
  input  logic [teb_pkg::CFG_DW-1:0]  pwdata,
  output logic [teb_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import teb_pkg::*;

  localparam int unsigned AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned LW = $clog2(STORE_BYTES + 1);
  localparam int unsigned SW = ((LW + 1 > DELTA_W) ? LW + 1 : DELTA_W) + 1;
  localparam int unsigned CW = (LW > RIDX_W) ? LW : RIDX_W;
  localparam logic [LW-1:0] ONE       = LW'(1);
  localparam logic [LW-1:0] STORE_LEN = LW'(STORE_BYTES);

  logic [CHAR_W-1:0] mem_q [STORE_BYTES];

  logic              typing_q, typing_d;
  logic [LW-1:0]     cursor_q, cursor_d;
  logic [LW-1:0]     length_q, length_d;
  logic [LW-1:0]     ptr_q, ptr_d;
  logic [LW-1:0]     col_q, col_d;
  logic [LW-1:0]     target_q, target_d;
  logic [CHAR_W-1:0] char_q;
  logic signed [DELTA_W-1:0] delta_q;
  logic [RIDX_W-1:0] ridx_q;
  logic              refused_q, refused_d;
  logic [CHAR_W-1:0] rdata_q;
  logic              done_q;
  logic [POS_W-1:0]  cursor_out_q, length_out_q;
  logic [CHAR_W-1:0] byte_out_q;
  logic              refused_out_q;

  ucw_t              cw;
  flags_t            flags;
  step_t             entry;
  logic              seq_busy;
  logic              accept;
  logic              full;
  logic              rd_nl;
  logic              cfg_sel;
  logic [LW-1:0]     ptr_m1, ptr_p1;
  logic [LW:0]       ptr_p1_wide;
  logic [LW:0]       col_sum;
  logic signed [SW-1:0] move_sum;
  logic signed [SW-1:0] len_s;
  logic [LW-1:0]     move_next;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic              ridx_valid;

  assign accept = start && !seq_busy;
  assign busy   = seq_busy;
  assign full   = (length_q >= STORE_LEN);

  always_comb begin
    entry     = S_FIN;
    refused_d = 1'b0;
    unique case (kind_e'(kind_i))
      K_INSERT: begin
        priority if (!typing_q) begin
          refused_d = 1'b1;
        end else if (char_code_i == CH_BACKSPACE) begin
          entry = (cursor_q != '0) ? S_BSP0 : S_FIN;
        end else if (full) begin
          refused_d = 1'b1;
        end else begin
          entry = S_INS0;
        end
      end
      K_BACKSP: entry = (typing_q && cursor_q != '0) ? S_BSP0 : S_FIN;
      K_DELETE: entry = (cursor_q < length_q) ? S_DEL0 : S_FIN;
      K_MOVE:   entry = S_MOV0;
      K_UP:     entry = S_UP0;
      K_DOWN:   entry = S_DN0;
      K_HOME:   entry = S_HOM0;
      K_END:    entry = S_END0;
      K_CLEAR:  entry = S_CLR0;
      K_APPEND: begin
        if (full) begin
          refused_d = 1'b1;
        end else begin
          entry = S_APP0;
        end
      end
      default:  entry = S_FIN;
    endcase
  end

  teb_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (accept),
    .entry_i (entry),
    .flags_i (flags),
    .ctrl_o  (cw),
    .busy_o  (seq_busy)
  );

  assign ptr_m1      = ptr_q - ONE;
  assign ptr_p1      = ptr_q + ONE;
  assign ptr_p1_wide = {1'b0, ptr_q} + {{LW{1'b0}}, 1'b1};
  assign rd_nl       = (rdata_q == CH_NEWLINE);

  assign flags.ptr_zero    = (ptr_q == '0);
  assign flags.ptr_eq_len  = (ptr_q == length_q);
  assign flags.ptr_eq_cur  = (ptr_q == cursor_q);
  assign flags.ptr1_ge_len = (ptr_p1_wide >= {1'b0, length_q});
  assign flags.rd_nnl      = !rd_nl;

  assign col_sum  = {1'b0, target_q} + {1'b0, col_q};
  assign move_sum = SW'($signed({1'b0, cursor_q})) + SW'(delta_q);
  assign len_s    = $signed(SW'(length_q));

  always_comb begin
    if (move_sum < 0) begin
      move_next = '0;
    end else if (move_sum > len_s) begin
      move_next = length_q;
    end else begin
      move_next = move_sum[LW-1:0];
    end
  end

  always_comb begin
    unique case (cw.pop)
      P_HOLD:  ptr_d = ptr_q;
      P_CUR:   ptr_d = cursor_q;
      P_CM1:   ptr_d = cursor_q - ONE;
      P_LEN:   ptr_d = length_q;
      P_INC:   ptr_d = ptr_p1;
      P_DEC:   ptr_d = ptr_m1;
      P_INCN:  ptr_d = rd_nl ? ptr_q : ptr_p1;
      P_DECN:  ptr_d = rd_nl ? ptr_q : ptr_m1;
      default: ptr_d = ptr_q;
    endcase

    unique case (cw.cop)
      C_HOLD:  cursor_d = cursor_q;
      C_INC:   cursor_d = cursor_q + ONE;
      C_DEC:   cursor_d = cursor_q - ONE;
      C_MOVE:  cursor_d = move_next;
      C_PTR:   cursor_d = ptr_q;
      C_COL:   cursor_d = (col_sum > {1'b0, ptr_q}) ? ptr_q : col_sum[LW-1:0];
      C_ZERO:  cursor_d = '0;
      C_LP1:   cursor_d = length_q + ONE;
      default: cursor_d = cursor_q;
    endcase

    unique case (cw.lop)
      L_HOLD:  length_d = length_q;
      L_INC:   length_d = length_q + ONE;
      L_DEC:   length_d = length_q - ONE;
      L_ZERO:  length_d = '0;
      default: length_d = length_q;
    endcase

    col_d    = col_q;
    target_d = target_q;
    unique case (cw.aux)
      A_NONE:  ;
      A_COL:   col_d = cursor_q - ptr_q;
      A_TGT:   target_d = ptr_q;
      default: ;
    endcase

    unique case (cw.rsel)
      RS_PTR:  mem_raddr = ptr_q[AW-1:0];
      RS_PM1:  mem_raddr = ptr_m1[AW-1:0];
      RS_PP1:  mem_raddr = ptr_p1[AW-1:0];
      RS_RIDX: mem_raddr = AW'(ridx_q);
      default: mem_raddr = ptr_q[AW-1:0];
    endcase

    mem_we    = 1'b1;
    mem_waddr = ptr_q[AW-1:0];
    mem_wdata = rdata_q;
    unique case (cw.wsel)
      WS_NONE: mem_we = 1'b0;
      WS_PTR:  ;
      WS_CUR: begin
        mem_waddr = cursor_q[AW-1:0];
        mem_wdata = char_q;
      end
      WS_LEN: begin
        mem_waddr = length_q[AW-1:0];
        mem_wdata = char_q;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign cfg_sel  = (paddr[CFG_AW-1:2] == REG_TYPING);
  assign typing_d = (psel && penable && pwrite && cfg_sel) ? pwdata[0] : typing_q;
  assign prdata   = cfg_sel ? {{(CFG_DW-1){1'b0}}, typing_q} : '0;
  assign pready   = 1'b1;

  assign ridx_valid = (CW'(ridx_q) < CW'(length_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      typing_q <= 1'b0;
      cursor_q <= '0;
      length_q <= '0;
      done_q   <= 1'b0;
    end else begin
      typing_q <= typing_d;
      cursor_q <= cursor_d;
      length_q <= length_d;
      done_q   <= cw.done;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    col_q    <= col_d;
    target_q <= target_d;
    if (accept) begin
      char_q    <= char_code_i;
      delta_q   <= move_delta_i;
      ridx_q    <= read_index_i;
      refused_q <= refused_d;
    end
    if (cw.done) begin
      cursor_out_q  <= POS_W'(cursor_q);
      length_out_q  <= POS_W'(length_q);
      byte_out_q    <= ridx_valid ? rdata_q : '0;
      refused_out_q <= refused_q;
    end
  end

  assign done_o       = done_q;
  assign cursor_out_o = cursor_out_q;
  assign length_out_o = length_out_q;
  assign byte_out_o   = byte_out_q;
  assign refused_o    = refused_out_q;

  a_cursor_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= length_q)
    else $error("cursor beyond end of text");

  a_length_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    length_q <= STORE_LEN)
    else $error("text length beyond store size");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted request did not start the sequencer");

endmodule
